// ===== hw/rtl/fpr_pkg.sv =====
// Shared types and constants for the FTP passive-mode reply parser.
package fpr_pkg;

  localparam int unsigned PREFIX_LEN = 27;
  localparam int unsigned NUM_COUNT  = 6;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned IDX_W      = 3;

  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [7:0] PREFIX_CHARS [PREFIX_LEN] = '{
    "2", "2", "7", " ", "E", "n", "t", "e", "r", "i", "n", "g", " ",
    "P", "a", "s", "s", "i", "v", "e", " ", "M", "o", "d", "e", " ", "("
  };

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_BODY   = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PREFIX = 3'd1,
    ST_INVALID    = 3'd2,
    ST_TOO_MANY   = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_TOO_FEW    = 3'd5,
    ST_OVER       = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_start;
  } fpr_item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] host_address;
    logic [15:0] port_number;
  } fpr_result_t;

  // Expected prefix character at a position; positions past the end give 8'h00.
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [7:0] c;
    c = 8'd0;
    if (32'(pos) < PREFIX_LEN) begin
      c = PREFIX_CHARS[pos];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fpr_in_stage.sv =====
// Input register stage: holds one character request for the parse logic.
module fpr_in_stage
  import fpr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic [7:0] ch_i,
  input  logic      line_start_i,
  input  logic      advance_i,
  output logic      item_valid_o,
  output fpr_item_t item_o
);

  logic      valid_q, valid_d;
  fpr_item_t item_q;

  // A held character leaves in the same cycle that a new one may enter.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.ch         <= ch_i;
      item_q.line_start <= line_start_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== hw/rtl/fpr_core.sv =====
// Parse state and per-character next-state and result logic.
module fpr_core
  import fpr_pkg::*;
#(
  parameter int unsigned BodyLimit = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  fpr_item_t   item_i,
  input  logic        out_free_i,
  output logic        advance_o,
  output logic        res_valid_o,
  output fpr_result_t res_o
);

  localparam int unsigned CntW = $clog2(BodyLimit + 1);

  phase_e           phase_q, phase_d, phase_e_eff;
  logic [POS_W-1:0] pos_q, pos_d, pos_eff;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_eff;
  logic [IDX_W-1:0] idx_q, idx_d, idx_eff, idx_sel;
  logic [7:0]       num_q [NUM_COUNT];
  logic [7:0]       num_d [NUM_COUNT];
  logic [7:0]       num_eff [NUM_COUNT];
  logic [11:0]      acc;
  logic             hit;
  status_e          status;
  logic [7:0]       ch;

  assign ch = item_i.ch;

  // A line start clears the parse before the character itself is handled.
  always_comb begin
    phase_e_eff = phase_q;
    pos_eff     = pos_q;
    cnt_eff     = cnt_q;
    idx_eff     = idx_q;
    for (int i = 0; i < NUM_COUNT; i++) begin
      num_eff[i] = item_i.line_start ? 8'd0 : num_q[i];
    end
    if (item_i.line_start) begin
      phase_e_eff = PH_PREFIX;
      pos_eff     = '0;
      cnt_eff     = '0;
      idx_eff     = '0;
    end
  end

  assign idx_sel = (idx_eff >= IDX_W'(NUM_COUNT - 1)) ? IDX_W'(NUM_COUNT - 1) : idx_eff;
  assign acc     = ({4'd0, num_eff[idx_sel]} << 3) + ({4'd0, num_eff[idx_sel]} << 1)
                 + {8'd0, ch[3:0]};

  always_comb begin
    phase_d = phase_e_eff;
    pos_d   = pos_eff;
    cnt_d   = cnt_eff;
    idx_d   = idx_eff;
    num_d   = num_eff;
    hit     = 1'b0;
    status  = ST_OK;
    unique case (phase_e_eff)
      PH_PREFIX: begin
        if (32'(pos_eff) >= PREFIX_LEN || ch != prefix_char(pos_eff)) begin
          hit    = 1'b1;
          status = ST_BAD_PREFIX;
        end else begin
          pos_d = pos_eff + POS_W'(1);
          if (32'(pos_d) == PREFIX_LEN) begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        priority if (ch == CHAR_CLOSE) begin
          hit    = 1'b1;
          status = (idx_eff == IDX_W'(NUM_COUNT - 1)) ? ST_OK : ST_TOO_FEW;
        end else if (cnt_eff >= CntW'(BodyLimit)) begin
          hit    = 1'b1;
          status = ST_TOO_LONG;
        end else begin
          cnt_d = cnt_eff + CntW'(1);
          priority if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            if (acc > 12'd255) begin
              hit    = 1'b1;
              status = ST_OVER;
            end else begin
              num_d[idx_sel] = acc[7:0];
            end
          end else if (ch == CHAR_COMMA) begin
            if (idx_sel >= IDX_W'(NUM_COUNT - 1)) begin
              hit    = 1'b1;
              status = ST_TOO_MANY;
            end else begin
              idx_d = idx_sel + IDX_W'(1);
            end
          end else begin
            hit    = 1'b1;
            status = ST_INVALID;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (hit) begin
      phase_d = PH_DONE;
    end
  end

  // A character that yields no result never waits on the output side.
  assign advance_o   = item_valid_i && (!hit || out_free_i);
  assign res_valid_o = advance_o && hit;

  always_comb begin
    res_o.status       = status;
    res_o.host_address = '0;
    res_o.port_number  = '0;
    if (status == ST_OK) begin
      res_o.host_address = {num_eff[0], num_eff[1], num_eff[2], num_eff[3]};
      res_o.port_number  = {num_eff[4], num_eff[5]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pos_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      for (int i = 0; i < NUM_COUNT; i++) begin
        num_q[i] <= 8'd0;
      end
    end else if (advance_o) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      num_q   <= num_d;
    end
  end

  a_result_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> phase_q == PH_DONE)
    else $error("parse did not stop after a result");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(NUM_COUNT - 1))
    else $error("number index past the last number");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= PREFIX_LEN)
    else $error("prefix position past the prefix");

  a_body_needs_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> 32'(pos_q) == PREFIX_LEN)
    else $error("body phase entered without a full prefix");

endmodule

// ===== hw/rtl/fpr_out_stage.sv =====
// Result register: holds one finished result until it is taken.
module fpr_out_stage
  import fpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  fpr_result_t res_i,
  output logic        out_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] host_address_o,
  output logic [15:0] port_number_o
);

  logic        valid_q, valid_d;
  fpr_result_t res_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign status_o       = res_q.status;
  assign host_address_o = res_q.host_address;
  assign port_number_o  = res_q.port_number;

endmodule

// ===== hw/rtl/ftp_passive_reply_parser_top.sv =====
// Top level of the FTP passive-mode reply parser.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   ch_i, line_start_i
//   out      output     out_valid_o/out_ready_i status_o, host_address_o, port_number_o
//
// One character is accepted per cycle unless a stall holds it; a character is parsed in
// the cycle after it is accepted, and its result, if any, goes to the result register.
// Reset clears the parse state to the start of a prefix and empties both registers.
// A result waiting on the output stalls only a character that itself gives a result;
// characters that give none keep flowing.
module ftp_passive_reply_parser_top
  import fpr_pkg::*;
#(
  parameter int unsigned BodyLimit = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        line_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] host_address_o,
  output logic [15:0] port_number_o
);

  logic        advance;
  logic        item_valid;
  fpr_item_t   item;
  logic        out_free;
  logic        res_valid;
  fpr_result_t res;

  fpr_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .ch_i         (ch_i),
    .line_start_i (line_start_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  fpr_core #(
    .BodyLimit (BodyLimit)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .advance_o    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  fpr_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (res_valid),
    .res_i          (res),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .host_address_o (host_address_o),
    .port_number_o  (port_number_o)
  );

endmodule

// ===== tb/fpr_checker.sv =====
// Checker for the FTP passive-mode reply parser: predicts each reply and compares it.
`timescale 1ns / 1ps
module fpr_checker
  import fpr_pkg::*;
#(
  parameter int unsigned BodyLimit = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        line_start_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] host_address_i,
  input  logic [15:0] port_number_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  phase_e           parse_phase;
  logic [POS_W-1:0] hdr_pos;
  logic [4:0]       body_len;
  logic [IDX_W-1:0] field_idx;
  logic [7:0]       fields [NUM_COUNT];

  fpr_result_t expected_replies [$];
  fpr_result_t want;
  int unsigned fails = 0;

  assign fail_count_o = fails;

  task automatic clear_parse();
    parse_phase = PH_PREFIX;
    hdr_pos     = '0;
    body_len    = '0;
    field_idx   = '0;
    foreach (fields[i]) fields[i] = '0;
  endtask

  task automatic push_reply(input status_e st);
    fpr_result_t r;
    r.status       = st;
    r.host_address = '0;
    r.port_number  = '0;
    if (st == ST_OK) begin
      r.host_address = {fields[0], fields[1], fields[2], fields[3]};
      r.port_number  = {fields[4], fields[5]};
    end
    expected_replies.push_back(r);
    parse_phase = PH_DONE;
  endtask

  // Advances the predicted parse by one character request.
  task automatic parse_char(input logic [7:0] c, input logic ls);
    logic [IDX_W-1:0] slot;
    int unsigned      acc;
    if (ls) clear_parse();
    case (parse_phase)
      PH_PREFIX: begin
        if (32'(hdr_pos) >= PREFIX_LEN) begin
          push_reply(ST_BAD_PREFIX);
        end else if (c != PREFIX_CHARS[hdr_pos]) begin
          push_reply(ST_BAD_PREFIX);
        end else begin
          hdr_pos = hdr_pos + 1'b1;
          if (32'(hdr_pos) == PREFIX_LEN) parse_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        slot = (32'(field_idx) >= NUM_COUNT) ? IDX_W'(NUM_COUNT - 1) : field_idx;
        if (c == CHAR_CLOSE) begin
          if (32'(field_idx) == NUM_COUNT - 1) begin
            push_reply(ST_OK);
          end else begin
            push_reply(ST_TOO_FEW);
          end
        end else if (32'(body_len) >= BodyLimit) begin
          push_reply(ST_TOO_LONG);
        end else begin
          body_len = body_len + 1'b1;
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            acc = 32'(fields[slot]) * 10 + 32'(c - CHAR_ZERO);
            if (acc > 255) begin
              push_reply(ST_OVER);
            end else begin
              fields[slot] = acc[7:0];
            end
          end else if (c == CHAR_COMMA) begin
            if (32'(slot) >= NUM_COUNT - 1) begin
              push_reply(ST_TOO_MANY);
            end else begin
              field_idx = slot + 1'b1;
            end
          end else begin
            push_reply(ST_INVALID);
          end
        end
      end
      default: ;
    endcase
  endtask

  // A reply always leaves the block later than the request that caused it,
  // so replies are matched before this edge's request is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_replies.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: reply with none expected: status %0d host %h port %h",
                   $time, status_i, host_address_i, port_number_i);
          fails++;
        end else begin
          want = expected_replies.pop_front();
          if (status_i != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fails++;
          end
          if (host_address_i != want.host_address) begin
            $display("%0t: host address expected %h actual %h",
                     $time, want.host_address, host_address_i);
            fails++;
          end
          if (port_number_i != want.port_number) begin
            $display("%0t: port number expected %h actual %h",
                     $time, want.port_number, port_number_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) parse_char(ch_i, line_start_i);
      pending_o <= expected_replies.size();
    end
  end

endmodule

// ===== tb/ftp_passive_reply_parser_top_test.sv =====
// Testbench top: feeds reply lines into the parser and reports the checker's verdict.
`timescale 1ns / 1ps
module ftp_passive_reply_parser_top_test;
  import fpr_pkg::*;

  localparam int unsigned BODY_LIMIT  = 24;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned CHAR_TARGET = 1200;
  localparam int unsigned LINE_TARGET = 25;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ch;
  logic        line_start;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic [31:0] host_address;
  logic [15:0] port_number;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned chars_sent  = 0;
  int unsigned lines_sent  = 0;
  int unsigned tail_count  = 0;
  bit          idling_on   = 1'b1;

  // Each entry is {line_start, character}.
  logic [8:0] line_buf [$];

  ftp_passive_reply_parser_top #(
    .BodyLimit(BODY_LIMIT)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .ch_i          (ch),
    .line_start_i  (line_start),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .host_address_o(host_address),
    .port_number_o (port_number)
  );

  fpr_checker #(
    .BodyLimit(BODY_LIMIT)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .ch_i          (ch),
    .line_start_i  (line_start),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .host_address_i(host_address),
    .port_number_i (port_number),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stalls come in random bursts, and new ones begin only while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void begin_line();
    line_buf.delete();
    tail_count = 0;
  endfunction

  function automatic void put_char(input logic [7:0] c);
    line_buf.push_back({line_buf.size() == 0, c});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void add_prefix(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) put_char(PREFIX_CHARS[i]);
  endfunction

  // Writes k comma-separated numbers; some are empty, some have a leading zero.
  function automatic void add_numbers(input int unsigned k);
    for (int unsigned i = 0; i < k; i++) begin
      if (i > 0) put_char(CHAR_COMMA);
      case ($urandom_range(0, 7))
        0: ;
        1: add_text("0");
        2: add_text("255");
        3: add_text($sformatf("0%0d", $urandom_range(0, 99)));
        default: add_text($sformatf("%0d", $urandom_range(0, 255)));
      endcase
    end
  endfunction

  function automatic void add_tail();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) put_char(8'($urandom_range(0, 255)));
    tail_count += n;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic ls);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    ch         <= c;
    line_start <= ls;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i][7:0], line_buf[i][8]);
    chars_sent += line_buf.size() - tail_count;
    lines_sent++;
  endtask

  // Holds off new requests until every predicted reply has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_random_line(input int unsigned pick);
    int unsigned n;
    int unsigned commas;
    logic [7:0]  c;
    begin_line();
    if (pick < 11) begin
      add_prefix(PREFIX_LEN);
      add_numbers(NUM_COUNT);
      put_char(CHAR_CLOSE);
      if ($urandom_range(0, 3) == 0) add_tail();
    end else if (pick < 13) begin
      n = $urandom_range(0, PREFIX_LEN - 1);
      add_prefix(n);
      case ($urandom_range(0, 3))
        0: c = 8'h00;
        1: c = PREFIX_CHARS[n] ^ (8'h01 << $urandom_range(0, 7));
        default: begin
          do c = 8'($urandom_range(0, 255)); while (c == PREFIX_CHARS[n]);
        end
      endcase
      put_char(c);
    end else if (pick < 17) begin
      add_prefix(PREFIX_LEN);
      case ($urandom_range(0, 4))
        0: begin
          add_numbers($urandom_range(0, NUM_COUNT));
          if ($urandom_range(0, 3) == 0) begin
            c = 8'h00;
          end else begin
            do c = 8'($urandom_range(0, 255));
            while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COMMA || c == CHAR_CLOSE);
          end
          put_char(c);
        end
        1: begin
          add_numbers(NUM_COUNT);
          put_char(CHAR_COMMA);
        end
        2: begin
          add_numbers($urandom_range(0, NUM_COUNT - 1));
          if ($urandom_range(0, 1) == 0) put_char(CHAR_COMMA);
          put_char(CHAR_CLOSE);
        end
        3: begin
          n = $urandom_range(0, NUM_COUNT - 1);
          add_numbers(n);
          if (n > 0) put_char(CHAR_COMMA);
          add_text($sformatf("%0d", $urandom_range(256, 999)));
        end
        default: begin
          commas = 0;
          repeat (BODY_LIMIT) begin
            if (commas < NUM_COUNT - 1 && $urandom_range(0, 5) == 0) begin
              put_char(CHAR_COMMA);
              commas++;
            end else begin
              put_char(CHAR_ZERO);
            end
          end
          if ($urandom_range(0, 3) == 0) begin
            put_char(CHAR_CLOSE);
          end else begin
            put_char(8'($urandom_range(0, 255)));
          end
        end
      endcase
    end else if (pick < 19) begin
      // Abandoned line: the next line start must throw this parse away.
      n = $urandom_range(1, PREFIX_LEN);
      add_prefix(n);
      if (n == PREFIX_LEN) add_numbers($urandom_range(0, NUM_COUNT));
    end else begin
      n = $urandom_range(1, 8);
      put_char(8'($urandom_range(0, 255)));
      repeat (n - 1) line_buf.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
      tail_count = n - 1;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    ch         = 8'h00;
    line_start = 1'b0;
    out_ready  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines: extremes, every status and the odd corners of the grammar.
    begin_line(); add_prefix(PREFIX_LEN); add_text("192,168,1,2,7,138)"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("255,255,255,255,255,255)"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("0,0,0,0,0,0)"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text(",,,,,)"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2,3,4,5,00000000000000)"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("0000000000000000000000007"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2,3,4,5,6,"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2,3)"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text(")"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2,3,4,5,256"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("999"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2a"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2"); put_char(8'h00); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("1,2,3,4,5,6)xy)"); put_char(8'h00);
    tail_count = 4;
    send_line();
    begin_line(); add_text("X"); send_line();
    begin_line(); add_prefix(9); put_char(8'h00); send_line();
    begin_line(); add_prefix(PREFIX_LEN - 1); add_text("["); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("10,20"); send_line();
    begin_line(); add_prefix(PREFIX_LEN); add_text("10,20,30,40,50,60)"); send_line();
    drain();

    while (chars_sent < CHAR_TARGET || lines_sent < LINE_TARGET) begin
      if ($urandom_range(0, 7) == 0) idling_on = !idling_on;
      if ($urandom_range(0, 15) == 0) drain();
      build_random_line($urandom_range(0, 19));
      send_line();
    end

    // Closing stretch at full rate on both sides.
    idling_on = 1'b0;
    repeat (6) begin
      build_random_line(0);
      send_line();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
